// ===== hw/rtl/wsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types and constants for the WebSocket frame encoder: field widths,
// request function codes, length-form thresholds and the header field bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfe_pkg;

	localparam int LEN_W = 63;
	localparam int KEY_W = 32;
	localparam int IDX_W = 4;

	// Function codes of an input request
	localparam logic FUNC_HEADER  = 1'b0;
	localparam logic FUNC_PAYLOAD = 1'b1;

	// Length forms
	localparam logic [LEN_W-1:0] LEN_DIRECT_MAX = 63'd125;
	localparam logic [LEN_W-1:0] LEN_SHORT_MAX  = 63'd65535;
	localparam logic [6:0]       CODE_LEN16     = 7'd126;
	localparam logic [6:0]       CODE_LEN64     = 7'd127;

	// Header byte positions and counts
	localparam logic [IDX_W-1:0] IDX_FLAGS   = 4'd0;
	localparam logic [IDX_W-1:0] IDX_LENGTH  = 4'd1;
	localparam logic [IDX_W-1:0] HDR_BASE_N  = 4'd2;
	localparam logic [IDX_W-1:0] EXT16_N     = 4'd2;
	localparam logic [IDX_W-1:0] EXT64_N     = 4'd8;
	localparam logic [IDX_W-1:0] KEY_N       = 4'd4;
	localparam logic [IDX_W-1:0] IDX_MAX     = 4'd13;

	// Header fields of the frame being started
	typedef struct packed {
		logic             fin;
		logic [2:0]       rsv;
		logic [3:0]       opc;
		logic             msk;
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] key;
	} hdr_fields_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsfe_hdr_gen.sv =====
// ----------------------------------------------------------------------------
// wsfe_hdr_gen
// Picks header byte number idx of a frame: flags byte, length byte, 2- or
// 8-byte big-endian extended length, then the four key bytes when masked.
// Flags the last header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_hdr_gen (
	input  wire wsfe_pkg::hdr_fields_t        hdr,
	input  wire logic [wsfe_pkg::IDX_W-1:0]   idx,
	output logic [7:0]                        hdr_byte,
	output logic                              hdr_last
);

	logic                        len_direct;
	logic                        len_short;
	logic [wsfe_pkg::IDX_W-1:0]  ext_n;
	logic [wsfe_pkg::IDX_W-1:0]  hdr_n;
	logic [6:0]                  len_code;
	logic [wsfe_pkg::IDX_W-1:0]  ext_k;
	logic [wsfe_pkg::IDX_W-1:0]  key_k;
	logic [63:0]                 len64;
	logic [2:0]                  len_sel;
	logic [1:0]                  key_sel;

	// Length form and header byte count
	always_comb begin
		len_direct = (hdr.len <= wsfe_pkg::LEN_DIRECT_MAX);
		len_short  = !len_direct && (hdr.len <= wsfe_pkg::LEN_SHORT_MAX);
		if (len_direct) begin
			ext_n    = '0;
			len_code = hdr.len[6:0];
		end else if (len_short) begin
			ext_n    = wsfe_pkg::EXT16_N;
			len_code = wsfe_pkg::CODE_LEN16;
		end else begin
			ext_n    = wsfe_pkg::EXT64_N;
			len_code = wsfe_pkg::CODE_LEN64;
		end
		hdr_n    = wsfe_pkg::HDR_BASE_N + ext_n + (hdr.msk ? wsfe_pkg::KEY_N : '0);
		hdr_last = (idx == hdr_n - 4'd1);
	end

	// Byte select: ext_k counts extended-length bytes, key_k key bytes
	always_comb begin
		ext_k   = idx - wsfe_pkg::HDR_BASE_N;
		key_k   = idx - wsfe_pkg::HDR_BASE_N - ext_n;
		len64   = {1'b0, hdr.len};
		len_sel = ~ext_k[2:0];          // 7 - k, most significant byte first
		key_sel = ~key_k[1:0];          // 3 - k
		priority if (idx == wsfe_pkg::IDX_FLAGS) begin
			hdr_byte = {hdr.fin, hdr.rsv, hdr.opc};
		end else if (idx == wsfe_pkg::IDX_LENGTH) begin
			hdr_byte = {hdr.msk, len_code};
		end else if (idx < wsfe_pkg::HDR_BASE_N + ext_n) begin
			if (len_short) begin
				hdr_byte = ext_k[0] ? hdr.len[7:0] : hdr.len[15:8];
			end else begin
				hdr_byte = len64[{len_sel, 3'b000} +: 8];
			end
		end else begin
			hdr_byte = hdr.key[{key_sel, 3'b000} +: 8];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// Frames data per RFC 6455: a header request emits the 2..14 header bytes,
// a payload request emits one byte, XORed with the frame key when masked.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-------------------
//   item    | item_valid, item_stall, func .. data_byte | header/payload in
//   byte    | byte_valid, byte_stall, out_byte,         | frame bytes out
//           | run_last, overrun                         |
//
// A header request emits its header bytes one at a time through the single
// output byte register and holds the input stage until its last byte moves on.
// Payload requests are taken every cycle while the output register drains.
// Reset clears the frame state (length left, key, mask flag, key position).
// byte_stall holds the output register and backs up into item_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input requests
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          func,
	input  wire logic                          final_flag,
	input  wire logic [2:0]                    reserved_bits,
	input  wire logic [3:0]                    frame_opcode,
	input  wire logic                          mask_enable,
	input  wire logic [wsfe_pkg::LEN_W-1:0]    frame_length,
	input  wire logic [wsfe_pkg::KEY_W-1:0]    frame_key,
	input  wire logic [7:0]                    data_byte,
	// output bytes
	output logic                               byte_valid,
	input  wire logic                          byte_stall,
	output logic [7:0]                         out_byte,
	output logic                               run_last,
	output logic                               overrun
);

	// Input stage
	logic                          valid_s1;
	logic                          func_s1;
	wsfe_pkg::hdr_fields_t         hdr_s1;
	logic [7:0]                    data_s1;
	logic [wsfe_pkg::IDX_W-1:0]    idx_q;

	// Frame state
	logic [wsfe_pkg::LEN_W-1:0]    bytes_left_q;
	logic [wsfe_pkg::KEY_W-1:0]    key_store_q;
	logic                          masking_on_q;
	logic [1:0]                    key_position_q;

	// Output register
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          run_last_q;
	logic                          overrun_q;

	logic                          is_hdr;
	logic                          out_adv;
	logic                          s1_done;
	logic                          in_take;
	logic [7:0]                    hdr_byte;
	logic                          hdr_last;
	logic                          pay_over;
	logic [7:0]                    key_byte;
	logic [7:0]                    pay_byte;

	wsfe_hdr_gen u_hdr_gen (
		.hdr      (hdr_s1),
		.idx      (idx_q),
		.hdr_byte (hdr_byte),
		.hdr_last (hdr_last)
	);

	// Handshake control
	always_comb begin
		is_hdr     = valid_s1 && (func_s1 == wsfe_pkg::FUNC_HEADER);
		out_adv    = !out_valid_q || !byte_stall;
		s1_done    = valid_s1 && out_adv && (!is_hdr || hdr_last);
		item_stall = valid_s1 && !s1_done;
		in_take    = item_valid && !item_stall;
	end

	// Payload byte: key byte at current position, bypass when past length
	always_comb begin
		pay_over = (bytes_left_q == '0);
		unique case (key_position_q)
			2'd0:    key_byte = key_store_q[31:24];
			2'd1:    key_byte = key_store_q[23:16];
			2'd2:    key_byte = key_store_q[15:8];
			default: key_byte = key_store_q[7:0];
		endcase
		pay_byte = (masking_on_q && !pay_over) ? (data_s1 ^ key_byte) : data_s1;
	end

	// Input stage control and header byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				idx_q    <= '0;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
				idx_q    <= '0;
			end else if (is_hdr && out_adv) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1    <= func;
			hdr_s1.fin <= final_flag;
			hdr_s1.rsv <= reserved_bits;
			hdr_s1.opc <= frame_opcode;
			hdr_s1.msk <= mask_enable;
			hdr_s1.len <= frame_length;
			hdr_s1.key <= frame_key;
			data_s1    <= data_byte;
		end
	end

	// Frame state: loaded by header bytes, advanced by in-range payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q   <= '0;
			key_store_q    <= '0;
			masking_on_q   <= 1'b0;
			key_position_q <= '0;
		end else if (valid_s1 && out_adv) begin
			if (is_hdr) begin
				bytes_left_q   <= hdr_s1.len;
				key_store_q    <= hdr_s1.key;
				masking_on_q   <= hdr_s1.msk;
				key_position_q <= '0;
			end else if (!pay_over) begin
				bytes_left_q   <= bytes_left_q - 63'd1;
				key_position_q <= key_position_q + 2'd1;
			end
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (valid_s1 && out_adv) begin
			if (is_hdr) begin
				out_byte_q <= hdr_byte;
				run_last_q <= hdr_last;
				overrun_q  <= 1'b0;
			end else begin
				out_byte_q <= pay_byte;
				run_last_q <= 1'b1;
				overrun_q  <= pay_over;
			end
		end
	end

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign overrun    = overrun_q;

`ifndef NO_ASSERTIONS
	// Overrun only on payload results, which are always single
	a_ovr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overrun_q |-> run_last_q)
		else $error("overrun on a non-final result");

	// Input is only held off while a request occupies the input stage
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	// Header index stays inside the longest header
	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		is_hdr |-> idx_q <= wsfe_pkg::IDX_MAX)
		else $error("header index out of range");

	// An in-range payload byte consumes exactly one from the length
	a_len_dec: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_hdr && out_adv && !pay_over
		|=> bytes_left_q == 63'($past(bytes_left_q) - 63'd1))
		else $error("remaining length not decremented");
`endif

endmodule

`default_nettype wire
